// ===== src/xlb_pkg.sv =====
// Shared types and constants of the GF(2) linear basis core.
// Used by xlb_cell, xor_linear_basis_core and xlb_checker; depends on nothing.
package xlb_pkg;

    localparam int BASIS_BITS_DEF = 63;
    localparam int VALUE_W        = 63;
    localparam int OP_W           = 2;
    localparam int ROW_W          = 6;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_CHECK  = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

    typedef struct packed {
        logic             valid;
        logic [OP_W-1:0]  op;
        logic             hit;
        logic             miss;
        logic [ROW_W-1:0] row;
    } stage_t;

endpackage

// ===== src/xlb_cell.sv =====
// One cell of the reduction chain: holds the basis row for one leading bit.
// Depends on xlb_pkg for the opcode codes and the stage control struct.
module xlb_cell #(
    parameter int BASIS_BITS = xlb_pkg::BASIS_BITS_DEF,
    parameter int CELL_IDX   = 0
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  advance,
    input  xlb_pkg::stage_t       ctl_in,
    input  logic [BASIS_BITS-1:0] vec_in,
    output xlb_pkg::stage_t       ctl_out,
    output logic [BASIS_BITS-1:0] vec_out
);

    logic [BASIS_BITS-1:0] row_reg;
    logic [BASIS_BITS-1:0] row_next;
    xlb_pkg::stage_t       ctl_reg;
    xlb_pkg::stage_t       ctl_next;
    logic [BASIS_BITS-1:0] vec_reg;
    logic [BASIS_BITS-1:0] vec_next;
    logic                  active;

    assign active = ctl_in.valid && !ctl_in.hit && !ctl_in.miss &&
                    (ctl_in.op inside {xlb_pkg::OP_INSERT, xlb_pkg::OP_CHECK});

    always_comb
    begin
        row_next = row_reg;
        ctl_next = ctl_in;
        vec_next = vec_in;
        if (ctl_in.valid && ctl_in.op == xlb_pkg::OP_CLEAR)
        begin
            row_next = '0;
        end
        else if (active && vec_in[CELL_IDX])
        begin
            if (row_reg == '0)
            begin
                if (ctl_in.op == xlb_pkg::OP_INSERT)
                begin
                    row_next     = vec_in;
                    ctl_next.hit = 1'b1;
                    ctl_next.row = xlb_pkg::ROW_W'(CELL_IDX);
                    vec_next     = '0;
                end
                else
                begin
                    ctl_next.miss = 1'b1;
                end
            end
            else
            begin
                vec_next = vec_in ^ row_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= '0;
            ctl_reg <= '0;
        end
        else if (advance)
        begin
            row_reg <= row_next;
            ctl_reg <= ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            vec_reg <= vec_next;
        end
    end

    assign ctl_out = ctl_reg;
    assign vec_out = vec_reg;

endmodule

// ===== src/xor_linear_basis_core.sv =====
// Top level of the GF(2) linear basis core: a chain of xlb_cell stages and an
// output register that also keeps the rank. Depends on xlb_pkg and xlb_cell.
//
//   channel   direction  handshake               fields
//   request   in         in_valid / in_stall     opcode, value
//   result    out        out_valid / out_stall   in_span, stored, stored_row, rank
//
// One request enters per cycle while in_stall is low.
// Each request meets every row at least one cell behind the request before it.
// Reset empties all rows and clears the rank; no clearing pass is needed.
// A held result freezes the whole chain and raises in_stall.
module xor_linear_basis_core #(
    parameter int BASIS_BITS = xlb_pkg::BASIS_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [xlb_pkg::OP_W-1:0]     opcode,
    input  logic [xlb_pkg::VALUE_W-1:0]  value,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic                         in_span,
    output logic                         stored,
    output logic [xlb_pkg::ROW_W-1:0]    stored_row,
    output logic [xlb_pkg::ROW_W-1:0]    rank
);

    logic                        advance;
    logic [BASIS_BITS-1:0]       vec_first;
    xlb_pkg::stage_t             ctl_c [0:BASIS_BITS];
    logic [BASIS_BITS-1:0]       vec_c [0:BASIS_BITS];
    xlb_pkg::stage_t             last;

    logic                        out_valid_reg;
    logic                        in_span_reg;
    logic                        in_span_next;
    logic                        stored_reg;
    logic [xlb_pkg::ROW_W-1:0]   stored_row_reg;
    logic [xlb_pkg::ROW_W-1:0]   rank_reg;
    logic [xlb_pkg::ROW_W-1:0]   rank_next;

    assign advance  = !out_valid_reg || !out_stall;
    assign in_stall = !advance;

    generate
        if (BASIS_BITS <= xlb_pkg::VALUE_W)
        begin : g_trim
            assign vec_first = value[BASIS_BITS-1:0];
        end
        else
        begin : g_extend
            assign vec_first = {{(BASIS_BITS - xlb_pkg::VALUE_W){1'b0}}, value};
        end
    endgenerate

    always_comb
    begin
        ctl_c[0]       = '0;
        ctl_c[0].valid = in_valid;
        ctl_c[0].op    = opcode;
    end
    assign vec_c[0] = vec_first;

    generate
        for (genvar k = 0; k < BASIS_BITS; k++)
        begin : g_chain
            xlb_cell #(
                .BASIS_BITS (BASIS_BITS),
                .CELL_IDX   (BASIS_BITS - 1 - k)
            ) u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .advance (advance),
                .ctl_in  (ctl_c[k]),
                .vec_in  (vec_c[k]),
                .ctl_out (ctl_c[k+1]),
                .vec_out (vec_c[k+1])
            );
        end
    endgenerate

    assign last = ctl_c[BASIS_BITS];

    always_comb
    begin
        in_span_next = (last.op inside {xlb_pkg::OP_INSERT, xlb_pkg::OP_CHECK}) &&
                       !last.hit && !last.miss;
        rank_next    = rank_reg;
        if (last.op == xlb_pkg::OP_CLEAR)
        begin
            rank_next = '0;
        end
        else if (last.hit)
        begin
            rank_next = rank_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            rank_reg      <= '0;
        end
        else if (advance)
        begin
            out_valid_reg <= last.valid;
            if (last.valid)
            begin
                rank_reg <= rank_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && last.valid)
        begin
            in_span_reg    <= in_span_next;
            stored_reg     <= last.hit;
            stored_row_reg <= last.hit ? last.row : '0;
        end
    end

    assign out_valid  = out_valid_reg;
    assign in_span    = in_span_reg;
    assign stored     = stored_reg;
    assign stored_row = stored_row_reg;
    assign rank       = rank_reg;

endmodule

// ===== src/xlb_checker.sv =====
// Port-level checks of xor_linear_basis_core and the bind that attaches them.
// Depends on xlb_pkg and on the port list of xor_linear_basis_core.
module xlb_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_stall,
    input logic                       out_valid,
    input logic                       out_stall,
    input logic                       in_span,
    input logic                       stored,
    input logic [xlb_pkg::ROW_W-1:0]  stored_row,
    input logic [xlb_pkg::ROW_W-1:0]  rank
);

    a_store_not_span: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && stored |-> !in_span)
        else $error("A stored request also reported span membership.");

    a_row_only_stored: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !stored |-> stored_row == '0)
        else $error("A nonzero row was reported without a store.");

    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |-> in_stall)
        else $error("Requests were taken while a result was held.");

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(rank) && $stable(stored))
        else $error("A stalled result changed.");

endmodule

bind xor_linear_basis_core xlb_checker u_xlb_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .in_span    (in_span),
    .stored     (stored),
    .stored_row (stored_row),
    .rank       (rank)
);

// ===== tb/tb_xor_linear_basis_core.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for xor_linear_basis_core: directed and random requests with a
// predictor of the GF(2) basis that checks every result. Depends on xlb_pkg and the core.
module tb_xor_linear_basis_core;

    localparam int                OP_W          = xlb_pkg::OP_W;
    localparam int                ROW_W         = xlb_pkg::ROW_W;
    localparam int                VALUE_W       = xlb_pkg::VALUE_W;
    localparam int                LEAD_ROWS     = xlb_pkg::BASIS_BITS_DEF;
    localparam logic [OP_W-1:0]   OP_NONE       = 2'd3;
    localparam int                RANDOM_ITEMS  = 1600;
    localparam int                CALM_AT       = 1450;
    localparam int                DRAIN_AT      = 900;
    localparam int                HOLDOFF_AT    = 500;
    localparam int                HOLDOFF_LEN   = 300;
    localparam int                QUIET_LIMIT   = 2000;
    localparam int                TAIL_CYCLES   = 80;

    typedef struct packed {
        logic             in_span;
        logic             stored;
        logic [ROW_W-1:0] row;
        logic [ROW_W-1:0] rank;
    } basis_result_t;

    class basis_tracker;
        logic [VALUE_W-1:0] lead_rows [LEAD_ROWS];
        logic [ROW_W-1:0]   filled;
        basis_result_t      pending_results [$];
        int                 errors;

        function new();
            foreach (lead_rows[i]) lead_rows[i] = '0;
            filled = '0;
            errors = 0;
        endfunction

        function void take_request(logic [OP_W-1:0] op, logic [VALUE_W-1:0] val);
            basis_result_t      res;
            logic [VALUE_W-1:0] v;
            bit                 halted;
            res = '0;
            v = val;
            halted = 1'b0;
            if (op == xlb_pkg::OP_INSERT || op == xlb_pkg::OP_CHECK)
            begin
                for (int i = LEAD_ROWS - 1; i >= 0 && !halted; i--)
                begin
                    if (v[i])
                    begin
                        if (lead_rows[i] == '0)
                        begin
                            if (op == xlb_pkg::OP_INSERT)
                            begin
                                lead_rows[i] = v;
                                res.stored = 1'b1;
                                res.row = i[ROW_W-1:0];
                                filled = filled + 1'b1;
                            end
                            halted = 1'b1;
                        end
                        else
                        begin
                            v = v ^ lead_rows[i];
                        end
                    end
                end
                if (!halted) res.in_span = (v == '0);
            end
            else if (op == xlb_pkg::OP_CLEAR)
            begin
                foreach (lead_rows[i]) lead_rows[i] = '0;
                filled = '0;
            end
            res.rank = filled;
            pending_results = {pending_results, res};
        endfunction

        function void match_result(basis_result_t got);
            basis_result_t want;
            if (pending_results.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("Unexpected result: in_span=%0d stored=%0d row=%0d rank=%0d",
                             got.in_span, got.stored, got.row, got.rank);
                return;
            end
            want = pending_results.pop_front();
            if (got !== want)
            begin
                errors++;
                if (errors <= 10)
                    $display({"Mismatch: expected in_span=%0d stored=%0d row=%0d rank=%0d, ",
                              "got in_span=%0d stored=%0d row=%0d rank=%0d"},
                             want.in_span, want.stored, want.row, want.rank,
                             got.in_span, got.stored, got.row, got.rank);
            end
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    logic [OP_W-1:0]      opcode;
    logic [VALUE_W-1:0]   value;
    logic                 out_valid;
    logic                 out_stall;
    logic                 in_span;
    logic                 stored;
    logic [ROW_W-1:0]     stored_row;
    logic [ROW_W-1:0]     rank;

    basis_tracker tracker = new();
    int           n_sent;
    int           quiet_cycles;
    bit           calm;

    xor_linear_basis_core u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .opcode     (opcode),
        .value      (value),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .in_span    (in_span),
        .stored     (stored),
        .stored_row (stored_row),
        .rank       (rank)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    task automatic offer_request(logic [OP_W-1:0] op, logic [VALUE_W-1:0] val);
        in_valid <= 1'b1;
        opcode <= op;
        value <= val;
        do @(negedge clk); while (in_stall);
        tracker.take_request(op, val);
        n_sent++;
        @(posedge clk);
    endtask

    task automatic idle_sender(int cycles);
        in_valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    function automatic logic [VALUE_W-1:0] pick_value();
        logic [63:0]        w;
        logic [VALUE_W-1:0] v;
        int                 r;
        int                 k;
        w = {$urandom(), $urandom()};
        v = w[VALUE_W-1:0];
        r = $urandom_range(0, 99);
        if (r < 4)
        begin
            v = '0;
        end
        else if (r < 30)
        begin
            v = w[VALUE_W-1:0];
        end
        else if (r < 45)
        begin
            k = $urandom_range(1, VALUE_W);
            v = w[VALUE_W-1:0] & ((({{(VALUE_W-1){1'b0}}, 1'b1}) << k) - 1'b1);
        end
        else if (r < 60)
        begin
            v = '0;
            repeat ($urandom_range(1, 3)) v[$urandom_range(0, VALUE_W - 1)] = 1'b1;
        end
        else if (r < 92)
        begin
            v = '0;
            foreach (tracker.lead_rows[i])
                if ($urandom_range(0, 1) == 1) v = v ^ tracker.lead_rows[i];
            if (r >= 80) v[$urandom_range(0, VALUE_W - 1)] ^= 1'b1;
        end
        else
        begin
            v[VALUE_W-1] = 1'b1;
        end
        return v;
    endfunction

    initial
    begin
        int               random_count;
        int               seg_len;
        int               insert_pct;
        int               idle_pct;
        int               r;
        bit               drained;
        logic [OP_W-1:0]  op;
        logic [VALUE_W-1:0] all_ones;

        all_ones = '1;
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        opcode <= xlb_pkg::OP_INSERT;
        value <= '0;
        n_sent = 0;
        calm = 1'b0;
        drained = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        offer_request(xlb_pkg::OP_INSERT, '0);
        offer_request(xlb_pkg::OP_CHECK, '0);
        offer_request(xlb_pkg::OP_INSERT, all_ones);
        offer_request(xlb_pkg::OP_CHECK, all_ones);
        offer_request(xlb_pkg::OP_INSERT, {1'b1, {(VALUE_W-1){1'b0}}});
        offer_request(xlb_pkg::OP_INSERT, 63'd1);
        offer_request(xlb_pkg::OP_CHECK, 63'd2);
        offer_request(xlb_pkg::OP_INSERT, all_ones);
        offer_request(OP_NONE, all_ones);
        offer_request(xlb_pkg::OP_CLEAR, '0);
        offer_request(xlb_pkg::OP_CHECK, all_ones);
        offer_request(xlb_pkg::OP_INSERT, 63'd1);
        offer_request(xlb_pkg::OP_INSERT, 63'd3);
        offer_request(xlb_pkg::OP_INSERT, 63'd2);
        offer_request(xlb_pkg::OP_CHECK, 63'h5555_5555_5555_5555);
        offer_request(OP_NONE, '0);
        for (int i = VALUE_W - 1; i >= VALUE_W - 6; i--)
            offer_request(xlb_pkg::OP_INSERT, all_ones >> (VALUE_W - 1 - i));
        offer_request(xlb_pkg::OP_CLEAR, all_ones);

        random_count = 0;
        while (random_count < RANDOM_ITEMS)
        begin
            seg_len = $urandom_range(10, 100);
            insert_pct = $urandom_range(20, 90);
            r = $urandom_range(0, 2);
            idle_pct = (r == 0) ? 0 : (r == 1) ? 10 : 30;
            offer_request(xlb_pkg::OP_CLEAR, pick_value());
            random_count++;
            for (int j = 0; j < seg_len && random_count < RANDOM_ITEMS; j++)
            begin
                calm = (random_count >= CALM_AT);
                if (!drained && random_count >= DRAIN_AT)
                begin
                    in_valid <= 1'b0;
                    while (tracker.pending_results.size() != 0) @(posedge clk);
                    drained = 1'b1;
                end
                r = $urandom_range(0, 99);
                if (r < 2)
                    op = OP_NONE;
                else if (r < 4)
                    op = xlb_pkg::OP_CLEAR;
                else if (r < 4 + (insert_pct * 96) / 100)
                    op = xlb_pkg::OP_INSERT;
                else
                    op = xlb_pkg::OP_CHECK;
                if (!calm && $urandom_range(0, 99) < idle_pct)
                    idle_sender($urandom_range(1, 11));
                offer_request(op, pick_value());
                if (op != OP_NONE) random_count++;
            end
        end

        in_valid <= 1'b0;
        while (tracker.pending_results.size() != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (tracker.errors == 0 && tracker.pending_results.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        int  stall_pct;
        bit  held_off;
        out_stall <= 1'b0;
        stall_pct = 10;
        held_off = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if ($urandom_range(0, 199) == 0) stall_pct = $urandom_range(0, 2) * 15;
            if (!held_off && n_sent >= HOLDOFF_AT)
            begin
                out_stall <= 1'b1;
                repeat (HOLDOFF_LEN) @(posedge clk);
                out_stall <= 1'b0;
                held_off = 1'b1;
            end
            else if (!calm && $urandom_range(0, 99) < stall_pct)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 11)) @(posedge clk);
                out_stall <= 1'b0;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    always @(negedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            tracker.match_result('{in_span, stored, stored_row, rank});
    end

    always @(negedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

endmodule

// ===== xor_linear_basis_core.f =====
src/xlb_pkg.sv
src/xlb_cell.sv
src/xor_linear_basis_core.sv
src/xlb_checker.sv
tb/tb_xor_linear_basis_core.sv
